>>> sv/spq_pkg.sv
// shared types and codes for the sorted priority queue
`default_nettype none

package spq_pkg;

  // default number of queue cells
  localparam int DEPTH_DEFAULT = 8;

  // field widths
  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  // packed port widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // request kinds
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic exec;     // apply the request to the cells and load the result
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/spq_ctrl.sv
// controller state machine for the sorted priority queue
`default_nettype none

module spq_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output spq_pkg::cmd_t    cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        // result register must be free or emptying this cycle
        if (!out_valid_r || out_tready) begin
          cmd.exec  = 1'b1;
          state_nxt = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_tvalid)
    else $error("executed request left no result");

  a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_tready)
    else $error("new item accepted while a request is pending");

  a_wait_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::ST_EXEC && out_tvalid && !out_tready) |=>
      (state_r == spq_pkg::ST_EXEC))
    else $error("request executed over an unread result");

endmodule

`default_nettype wire

>>> sv/spq_datapath.sv
// sorted cell array, request latch and result register
`default_nettype none

module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire spq_pkg::cmd_t                         cmd,
  input  wire logic                                  in_req,
  input  wire logic signed [spq_pkg::DATA_W-1:0]     in_data,
  input  wire logic signed [spq_pkg::PRIO_W-1:0]     in_prio,
  output logic signed [spq_pkg::DATA_W-1:0]          res_out_data,
  output logic [spq_pkg::STATUS_W-1:0]               res_status,
  output logic signed [spq_pkg::DATA_W-1:0]          res_head_data,
  output logic                                       res_head_valid,
  output logic [spq_pkg::COUNT_W-1:0]                res_count
);

  localparam int CW = $clog2(DEPTH + 1);

  // request latch
  logic                               req_r;
  logic signed [spq_pkg::DATA_W-1:0]  req_data_r;
  logic signed [spq_pkg::PRIO_W-1:0]  req_prio_r;

  // cells, slot 0 is the head
  logic signed [spq_pkg::DATA_W-1:0]  data_r   [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0]  prio_r   [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0]  data_nxt [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0]  prio_nxt [DEPTH];
  logic [CW-1:0]                      count_r, count_nxt;

  logic [DEPTH-1:0] mark;       // cell at or past the insert point
  logic [DEPTH-1:0] prev_mark;  // previous cell at or past the insert point
  logic             full, empty, do_enq, do_deq;
  logic [spq_pkg::STATUS_W-1:0]       status_c;
  logic signed [spq_pkg::DATA_W-1:0]  removed_c;
  logic [CW+spq_pkg::COUNT_W-1:0]     count_ext;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign do_enq = cmd.exec && (req_r == spq_pkg::REQ_ENQ) && !full;
  assign do_deq = cmd.exec && (req_r == spq_pkg::REQ_DEQ) && !empty;

  // compare in every cell; sorted order makes the marks a run to the tail
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      mark[i] = (CW'(i) >= count_r) || (prio_r[i] >= req_prio_r);
    end
    prev_mark[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) begin
      prev_mark[i] = mark[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      data_nxt[i] = data_r[i];
      prio_nxt[i] = prio_r[i];
    end
    count_nxt = count_r;
    if (do_enq) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (prev_mark[i]) begin
          data_nxt[i] = data_r[(i == 0) ? 0 : i-1];
          prio_nxt[i] = prio_r[(i == 0) ? 0 : i-1];
        end else if (mark[i]) begin
          data_nxt[i] = req_data_r;
          prio_nxt[i] = req_prio_r;
        end
      end
      count_nxt = count_r + CW'(1);
    end else if (do_deq) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        data_nxt[i] = data_r[i+1];
        prio_nxt[i] = prio_r[i+1];
      end
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    status_c = spq_pkg::STAT_OK;
    if (req_r == spq_pkg::REQ_ENQ && full) begin
      status_c = spq_pkg::STAT_FULL;
    end else if (req_r == spq_pkg::REQ_DEQ && empty) begin
      status_c = spq_pkg::STAT_EMPTY;
    end
    removed_c = do_deq ? data_r[0] : '0;
    count_ext = {{spq_pkg::COUNT_W{1'b0}}, count_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      data_r[i] <= data_nxt[i];
      prio_r[i] <= prio_nxt[i];
    end
    if (cmd.capture) begin
      req_r      <= in_req;
      req_data_r <= in_data;
      req_prio_r <= in_prio;
    end
    if (cmd.exec) begin
      res_out_data   <= removed_c;
      res_status     <= status_c;
      res_head_valid <= (count_nxt != '0);
      res_head_data  <= (count_nxt != '0) ? data_nxt[0] : '0;
      res_count      <= count_ext[spq_pkg::COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue_unit.sv
// top level of the sorted priority queue
`default_nettype none

// channel  dir  tdata                                   tuser
// in_      in   [31:0] item_data [47:32] item_priority  [0] req_type (0 enq, 1 deq)
// out_     out  [31:0] out_data [63:32] head_data       [1:0] status
//               [64] head_valid [68:65] entry_count
//
// per item the request is latched in idle, then in exec (once the result register is free) every
// cell compares its priority with the new one and shifts or loads in parallel
// the cell array updates and the result register loads in the same cycle
// a new item is taken while a result still waits; that request then holds
// until the result register frees up
// synchronous active-low reset empties the queue, no clearing pass

module sorted_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [spq_pkg::IN_TDATA_W-1:0]    in_tdata,   // item_data, item_priority
  input  wire logic [0:0]                        in_tuser,   // req_type
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]        out_tdata,  // out_data, head_data,
                                                             // head_valid, entry_count, pad
  output logic [spq_pkg::STATUS_W-1:0]           out_tuser   // status
);

  spq_pkg::cmd_t cmd;

  logic signed [spq_pkg::DATA_W-1:0]  res_out_data;
  logic signed [spq_pkg::DATA_W-1:0]  res_head_data;
  logic                               res_head_valid;
  logic [spq_pkg::COUNT_W-1:0]        res_count;

  // sequencing of request capture, execution and result hand-off
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // sorted cells with a compare in each
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req         (in_tuser[0]),
    .in_data        (in_tdata[31:0]),
    .in_prio        (in_tdata[47:32]),
    .res_out_data   (res_out_data),
    .res_status     (out_tuser),
    .res_head_data  (res_head_data),
    .res_head_valid (res_head_valid),
    .res_count      (res_count)
  );

  // pack result fields, lowest first, zero pad to whole bytes
  assign out_tdata = {3'b000, res_count, res_head_valid, res_head_data, res_out_data};

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for the sorted priority queue unit
`timescale 1ns / 1ps

module tb_top;

  localparam int QUEUE_DEPTH   = spq_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 800;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake before giving up
  localparam int END_CYCLES    = 10;    // quiet cycles after the last result
  localparam int DIRECTED_ROWS = 22;

  // one result item as the block reports it
  typedef struct packed {
    logic [spq_pkg::DATA_W-1:0]   out_data;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::DATA_W-1:0]   head_data;
    logic                         head_valid;
    logic [spq_pkg::COUNT_W-1:0]  entry_count;
  } queue_result_t;

  // one row of the directed table; typed rows carry their result written out
  typedef struct packed {
    logic                       req;
    logic [spq_pkg::DATA_W-1:0] data;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic                       typed;
    queue_result_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [spq_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // item_data, item_priority
  logic [0:0]                     in_tuser = '0;   // req_type

  // result channel
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata;  // out_data, head_data, head_valid, entry_count, pad
  logic [spq_pkg::STATUS_W-1:0]    out_tuser;  // status

  sorted_priority_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow queue: sorted by ascending signed priority, slot 0 is the head
  // ---------------------------------------------------------------------------
  logic [spq_pkg::DATA_W-1:0]        shadow_data [QUEUE_DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
  int                                shadow_fill = 0;

  queue_result_t pending_results [$];  // expected results, oldest first

  int enq_count    = 0;
  int deq_count    = 0;
  int full_count   = 0;
  int empty_count  = 0;
  int results_seen = 0;
  int mismatches   = 0;

  // apply one request to the shadow queue and work out the result it yields
  function automatic queue_result_t apply_request(logic req, logic [spq_pkg::DATA_W-1:0] data,
                                                  logic [spq_pkg::PRIO_W-1:0] prio);
    queue_result_t                     res;
    logic signed [spq_pkg::PRIO_W-1:0] sprio;
    int                                pos;
    res   = '0;
    sprio = $signed(prio);
    res.status = spq_pkg::STAT_OK;
    if (req == spq_pkg::REQ_ENQ) begin
      enq_count++;
      if (shadow_fill >= QUEUE_DEPTH) begin
        // full: request dropped, queue left as it is
        res.status = spq_pkg::STAT_FULL;
        full_count++;
      end else begin
        // new entry goes ahead of every equal or larger priority, so ties serve newest first
        pos = shadow_fill;
        while (pos > 0 && shadow_prio[pos-1] >= sprio) begin
          shadow_data[pos] = shadow_data[pos-1];
          shadow_prio[pos] = shadow_prio[pos-1];
          pos--;
        end
        shadow_data[pos] = data;
        shadow_prio[pos] = sprio;
        shadow_fill++;
      end
    end else begin
      deq_count++;
      if (shadow_fill == 0) begin
        res.status = spq_pkg::STAT_EMPTY;
        empty_count++;
      end else begin
        res.out_data = shadow_data[0];
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_data[i-1] = shadow_data[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_fill--;
      end
    end
    // head and count describe the queue after the step
    res.head_valid  = (shadow_fill > 0);
    res.head_data   = (shadow_fill > 0) ? shadow_data[0] : '0;
    res.entry_count = shadow_fill[spq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one item and hold it until accepted; tvalid stays high afterwards
  task automatic send_item(logic req, logic [spq_pkg::DATA_W-1:0] data,
                           logic [spq_pkg::PRIO_W-1:0] prio,
                           logic typed, queue_result_t typed_result);
    queue_result_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, data};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // the shadow queue always advances, typed rows only swap in their written-out result
    predicted = apply_request(req, data, prio);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic idle_cycles(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [DIRECTED_ROWS];

  initial begin
    directed_rows = '{
      // dequeue straight after reset: empty status, nothing at the head
      '{spq_pkg::REQ_DEQ, 32'h0000_0000, 16'h0000, 1'b1,
        '{32'h0, spq_pkg::STAT_EMPTY, 32'h0, 1'b0, 4'd0}},
      // largest data at largest priority, then smallest at smallest
      '{spq_pkg::REQ_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b1,
        '{32'h0, spq_pkg::STAT_OK, 32'h7FFF_FFFF, 1'b1, 4'd1}},
      '{spq_pkg::REQ_ENQ, 32'h8000_0000, 16'h8000, 1'b1,
        '{32'h0, spq_pkg::STAT_OK, 32'h8000_0000, 1'b1, 4'd2}},
      '{spq_pkg::REQ_ENQ, 32'h0000_0000, 16'h0000, 1'b0, '0},
      // equal priority: newest goes in front
      '{spq_pkg::REQ_ENQ, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0},
      '{spq_pkg::REQ_ENQ, 32'h1234_5678, 16'h7FFF, 1'b0, '0},
      '{spq_pkg::REQ_ENQ, 32'hA5A5_A5A5, 16'hFFFF, 1'b0, '0},
      '{spq_pkg::REQ_ENQ, 32'h5A5A_5A5A, 16'h8000, 1'b0, '0},
      '{spq_pkg::REQ_ENQ, 32'h0000_0001, 16'h0001, 1'b0, '0},
      // queue now full: enqueue dropped even at the best priority
      '{spq_pkg::REQ_ENQ, 32'hDEAD_BEEF, 16'h8000, 1'b1,
        '{32'h0, spq_pkg::STAT_FULL, 32'h5A5A_5A5A, 1'b1, 4'd8}},
      '{spq_pkg::REQ_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
      // drain in priority order, payload fields on a dequeue are ignored
      '{spq_pkg::REQ_DEQ, 32'hF0F0_F0F0, 16'hAAAA, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'h0F0F_0F0F, 16'h5555, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'h0000_0000, 16'h0000, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'h8000_0000, 16'h8000, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'hCAFE_F00D, 16'h1234, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'h0BAD_CAFE, 16'hFEDC, 1'b0, '0},
      '{spq_pkg::REQ_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
        '{32'h0, spq_pkg::STAT_EMPTY, 32'h0, 1'b0, 4'd0}},
      '{spq_pkg::REQ_ENQ, 32'hC3C3_C3C3, 16'h5555, 1'b1,
        '{32'h0, spq_pkg::STAT_OK, 32'hC3C3_C3C3, 1'b1, 4'd1}},
      // last entry out leaves the head empty
      '{spq_pkg::REQ_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
        '{32'hC3C3_C3C3, spq_pkg::STAT_OK, 32'h0, 1'b0, 4'd0}}
    };
  end

  // ---------------------------------------------------------------------------
  // main sequence: reset, directed table, random traffic, drain
  // ---------------------------------------------------------------------------
  initial begin
    int                         sent;
    int                         burst;
    int                         enq_pct;
    int                         phase_left;
    bit                         gapless;
    logic                       req;
    logic [spq_pkg::DATA_W-1:0] data;
    logic [spq_pkg::PRIO_W-1:0] prio;

    sent       = 0;
    enq_pct    = 50;
    phase_left = 0;
    gapless    = 1'b0;

    // synchronous reset, applied once
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].req, directed_rows[r].data, directed_rows[r].prio,
                directed_rows[r].typed, directed_rows[r].want);
      // a few gaps inside the table so idling hits the early states too
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
    end
    drain_results();

    // random traffic in phases: filling, draining or balanced, so the queue
    // keeps swinging between empty and full
    while (sent < RANDOM_ITEMS) begin
      if (phase_left <= 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 50;
        endcase
        gapless    = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(20, 60);
      end
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        req  = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
        data = $urandom;
        case ($urandom_range(0, 3))
          0, 1: prio = 16'($urandom);
          // narrow band around zero for plenty of ties, both signs
          2:    prio = 16'($urandom_range(0, 3)) - 16'd2;
          default: begin
            case ($urandom_range(0, 3))
              0:       prio = 16'h8000;
              1:       prio = 16'h7FFF;
              2:       prio = 16'h0000;
              default: prio = 16'hFFFF;
            endcase
          end
        endcase
        send_item(req, data, prio, 1'b0, '0);
        sent++;
        phase_left--;
        // halfway through, stop sending until the block has caught up
        if (sent == RANDOM_ITEMS / 2) drain_results();
      end
      if (!gapless) idle_cycles($urandom_range(1, 10));
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);

    $display("run: %0d items (%0d enqueues, %0d dequeues), %0d results checked",
             enq_count + deq_count, enq_count, deq_count, results_seen);
    $display("run: %0d enqueues refused as full, %0d dequeues found it empty, %0d mismatches",
             full_count, empty_count, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern changes mode periodically, driven by a counter of cycles
  // ---------------------------------------------------------------------------
  int rx_mode  = 0;
  int rx_cycle = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 63) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       out_tready <= 1'b1;                          // no back-pressure
      1:       out_tready <= 1'($urandom_range(0, 1));      // coin toss
      2:       out_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
      default: out_tready <= (rx_cycle % 3 != 0);           // regular pattern
    endcase
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  queue_result_t oldest_result;

  task automatic compare_field(string name, logic [spq_pkg::DATA_W-1:0] want,
                               logic [spq_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch on result %0d, expected %h, actual %h",
               $time, name, results_seen, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected, expected none, actual %h/%h",
                 $time, out_tdata, out_tuser);
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("out_data", oldest_result.out_data, out_tdata[31:0]);
        compare_field("status", 32'(oldest_result.status), 32'(out_tuser));
        compare_field("head_data", oldest_result.head_data, out_tdata[63:32]);
        compare_field("head_valid", 32'(oldest_result.head_valid), 32'(out_tdata[64]));
        compare_field("entry_count", 32'(oldest_result.entry_count), 32'(out_tdata[68:65]));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake on either side
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue_unit.sv
tb/sv/tb_top.sv
